### src/eased_transition_interpolator_top_macros.svh
// Assertion helpers for the eased transition interpolator.
`ifndef EASED_TRANSITION_INTERPOLATOR_TOP_MACROS_SVH
`define EASED_TRANSITION_INTERPOLATOR_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define ETI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define ETI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/eti_pkg.sv
// ----------------------------------------------------------------------------
// eti_pkg
// Shared types and codes of the eased transition interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eti_pkg;

  // Default build settings
  localparam int BISECT_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // Timing curve codes
  localparam logic [2:0] FUNC_LINEAR      = 3'd0;
  localparam logic [2:0] FUNC_EASE        = 3'd1;
  localparam logic [2:0] FUNC_EASE_IN     = 3'd2;
  localparam logic [2:0] FUNC_EASE_OUT    = 3'd3;
  localparam logic [2:0] FUNC_EASE_IN_OUT = 3'd4;

  // Phase codes
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // Fields that ride along the pipeline untouched
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] start_value;
    logic signed [32:0] diff;
    logic [1:0]         phase;
  } side_t;

endpackage

### src/eti_div_pipe.sv
// ----------------------------------------------------------------------------
// eti_div_pipe
// Pipelined restoring divider: progress = active * 2^F / duration, one
// quotient bit per stage, with waiting and saturated cases folded in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eti_div_pipe #(
  parameter int FRAC_BITS = eti_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [23:0]          active,
  input  logic [23:0]          duration,
  input  logic                 waiting,
  input  logic                 full,
  input  eti_pkg::side_t       in_side,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   x,
  output eti_pkg::side_t       out_side
);

  localparam int F = FRAC_BITS;

  logic [23:0]    rem_q  [F];
  logic [23:0]    dur_q  [F];
  logic [F-1:0]   quo_q  [F];
  logic           wait_q [F];
  logic           full_q [F];
  logic           vld_q  [F];
  eti_pkg::side_t side_q [F];

  for (genvar k = 0; k < F; k++) begin : g_stage
    logic [23:0]    rem_i;
    logic [23:0]    dur_i;
    logic [F-1:0]   quo_i;
    logic           wait_i;
    logic           full_i;
    logic           vld_i;
    eti_pkg::side_t side_i;
    logic [24:0]    r2;
    logic [24:0]    sub;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_i  = active;
      assign dur_i  = duration;
      assign quo_i  = '0;
      assign wait_i = waiting;
      assign full_i = full;
      assign vld_i  = in_valid;
      assign side_i = in_side;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign dur_i  = dur_q[k-1];
      assign quo_i  = quo_q[k-1];
      assign wait_i = wait_q[k-1];
      assign full_i = full_q[k-1];
      assign vld_i  = vld_q[k-1];
      assign side_i = side_q[k-1];
    end

    // one restoring step
    assign r2  = {rem_i, 1'b0};
    assign sub = r2 - {1'b0, dur_i};
    assign ge  = (r2 >= {1'b0, dur_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? sub[23:0] : r2[23:0];
        dur_q[k]  <= dur_i;
        quo_q[k]  <= {quo_i[F-2:0], ge};
        wait_q[k] <= wait_i;
        full_q[k] <= full_i;
        side_q[k] <= side_i;
      end
    end
  end

  // waiting gives zero, saturated gives one
  assign out_valid = vld_q[F-1];
  assign out_side  = side_q[F-1];
  assign x = wait_q[F-1] ? '0 :
             full_q[F-1] ? {1'b1, {F{1'b0}}} : {1'b0, quo_q[F-1]};

endmodule

### src/eti_bez_pipe.sv
// ----------------------------------------------------------------------------
// eti_bez_pipe
// Three-stage evaluation of one cubic Bezier coordinate at parameter t,
// for the x or the y control points of the selected curve.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eti_bez_pipe #(
  parameter int FRAC_BITS = eti_pkg::FRAC_BITS_DEF,
  parameter int AUX_W     = 1,
  parameter bit USE_Y     = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [FRAC_BITS:0]   t,
  input  eti_pkg::side_t       in_side,
  input  logic [AUX_W-1:0]     in_aux,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   s,
  output logic [FRAC_BITS:0]   t_out,
  output eti_pkg::side_t       out_side,
  output logic [AUX_W-1:0]     out_aux
);

  localparam int F = FRAC_BITS;
  localparam int W = F + 1;
  localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [W-1:0] P10 = W'(((64'd10 << F) + 64'd50) / 64'd100);
  localparam logic [W-1:0] P25 = W'(((64'd25 << F) + 64'd50) / 64'd100);
  localparam logic [W-1:0] P42 = W'(((64'd42 << F) + 64'd50) / 64'd100);
  localparam logic [W-1:0] P58 = W'(((64'd58 << F) + 64'd50) / 64'd100);

  // stage 1: u, u*u, t*t
  logic [W-1:0]   u;
  logic [2*W-1:0] uu_p, tt_p;
  logic [W-1:0]   t1, u1, uu1, tt1;
  logic           v1;
  eti_pkg::side_t side1;
  logic [AUX_W-1:0] aux1;

  assign u    = ONE - t;
  assign uu_p = {{W{1'b0}}, u} * {{W{1'b0}}, u};
  assign tt_p = {{W{1'b0}}, t} * {{W{1'b0}}, t};

  always_ff @(posedge clk) begin
    if (en) begin
      t1    <= t;
      u1    <= u;
      uu1   <= uu_p[F+W-1:F];
      tt1   <= tt_p[F+W-1:F];
      side1 <= in_side;
      aux1  <= in_aux;
    end
  end

  // stage 2: u*u*t, t*t*u, t*t*t
  logic [2*W-1:0] a_p, b_p, c_p;
  logic [W-1:0]   t2, a2, b2, ttt2;
  logic           v2;
  eti_pkg::side_t side2;
  logic [AUX_W-1:0] aux2;

  assign a_p = {{W{1'b0}}, uu1} * {{W{1'b0}}, t1};
  assign b_p = {{W{1'b0}}, tt1} * {{W{1'b0}}, u1};
  assign c_p = {{W{1'b0}}, tt1} * {{W{1'b0}}, t1};

  always_ff @(posedge clk) begin
    if (en) begin
      t2    <= t1;
      a2    <= a_p[F+W-1:F];
      b2    <= b_p[F+W-1:F];
      ttt2  <= c_p[F+W-1:F];
      side2 <= side1;
      aux2  <= aux1;
    end
  end

  // stage 3: weight by the control points, sum and clamp
  logic [W-1:0]   p1, p2;
  logic [W+1:0]   p1x3, p2x3;
  logic [2*W+1:0] m1, m2;
  logic [W+2:0]   sum;
  logic [W-1:0]   s3, t3;
  logic           v3;
  eti_pkg::side_t side3;
  logic [AUX_W-1:0] aux3;

  always_comb begin
    unique case (side2.func)
      eti_pkg::FUNC_EASE: begin
        p1 = USE_Y ? P10 : P25;
        p2 = USE_Y ? ONE : P25;
      end
      eti_pkg::FUNC_EASE_IN: begin
        p1 = USE_Y ? '0 : P42;
        p2 = ONE;
      end
      eti_pkg::FUNC_EASE_OUT: begin
        p1 = '0;
        p2 = USE_Y ? ONE : P58;
      end
      eti_pkg::FUNC_EASE_IN_OUT: begin
        p1 = USE_Y ? '0 : P42;
        p2 = USE_Y ? ONE : P58;
      end
      default: begin
        p1 = '0;
        p2 = '0;
      end
    endcase
  end

  assign p1x3 = {2'b00, p1} + {1'b0, p1, 1'b0};
  assign p2x3 = {2'b00, p2} + {1'b0, p2, 1'b0};
  assign m1   = {{(W+2){1'b0}}, a2} * {{W{1'b0}}, p1x3};
  assign m2   = {{(W+2){1'b0}}, b2} * {{W{1'b0}}, p2x3};
  assign sum  = {1'b0, m1[F+W+1:F]} + {1'b0, m2[F+W+1:F]} + {3'b000, ttt2};

  always_ff @(posedge clk) begin
    if (en) begin
      s3    <= (sum > {3'b000, ONE}) ? ONE : sum[W-1:0];
      t3    <= t2;
      side3 <= side2;
      aux3  <= aux2;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;
  assign s         = s3;
  assign t_out     = t3;
  assign out_side  = side3;
  assign out_aux   = aux3;

endmodule

### src/eti_bisect_step.sv
// ----------------------------------------------------------------------------
// eti_bisect_step
// One bisection step on the curve x coordinate: evaluates x at the
// midpoint and narrows the bracket towards the target progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eti_bisect_step #(
  parameter int FRAC_BITS = eti_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  eti_pkg::side_t       in_side,
  input  logic [FRAC_BITS:0]   x,
  input  logic [FRAC_BITS:0]   lo,
  input  logic [FRAC_BITS:0]   hi,
  output logic                 out_valid,
  output eti_pkg::side_t       out_side,
  output logic [FRAC_BITS:0]   x_out,
  output logic [FRAC_BITS:0]   lo_out,
  output logic [FRAC_BITS:0]   hi_out
);

  localparam int W = FRAC_BITS + 1;

  logic [W:0]     mid_sum;
  logic [W-1:0]   mid, s, mid_d, x_d, lo_d, hi_d;
  logic [3*W-1:0] aux_d;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[W:1];

  eti_bez_pipe #(
    .FRAC_BITS (FRAC_BITS),
    .AUX_W     (3 * W),
    .USE_Y     (1'b0)
  ) u_bez (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .t         (mid),
    .in_side   (in_side),
    .in_aux    ({x, lo, hi}),
    .out_valid (out_valid),
    .s         (s),
    .t_out     (mid_d),
    .out_side  (out_side),
    .out_aux   (aux_d)
  );

  assign {x_d, lo_d, hi_d} = aux_d;

  // narrow the bracket
  assign x_out  = x_d;
  assign lo_out = (s < x_d) ? mid_d : lo_d;
  assign hi_out = (s < x_d) ? hi_d : mid_d;

endmodule

### src/eased_transition_interpolator_top.sv
// ----------------------------------------------------------------------------
// eased_transition_interpolator_top
// Timed transition step: progress from elapsed, delay and duration,
// eased by a cubic Bezier curve, then interpolated between two values.
// ----------------------------------------------------------------------------
//
//  channel | role   | tdata (low bit up)                          | tuser
//  s_*     | input  | elapsed 24, delay 24, duration 24,          | func 3
//          |        | start_value 32, end_value 32                |
//  m_*     | output | current_value 32, eased_progress 17, pad 7  | phase 2
//
// One word per cycle in and out while no result waits on m_tready. The
// pipeline has one stage per quotient bit of the divider, three per curve
// evaluation (two multiply stages and a weighting stage), plus input,
// product and output registers.
// Reset is synchronous and clears only valid bits. While a result waits on
// m_tready the whole pipeline holds and s_tready is low.
`timescale 1ns / 1ps

module eased_transition_interpolator_top #(
  parameter int BISECT_STEPS = eti_pkg::BISECT_STEPS_DEF,
  parameter int FRAC_BITS    = eti_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // elapsed_time, delay_time, duration_time,
                                  // start_value, end_value
  input  logic [2:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,   // current_value, eased_progress, zero pad
  output logic [1:0]   m_tuser    // phase
);

  `include "eased_transition_interpolator_top_macros.svh"

  localparam int F  = FRAC_BITS;
  localparam int W  = F + 1;
  localparam int N  = BISECT_STEPS;
  localparam int PW = 34 + W;
  localparam logic [W-1:0] ONE = {1'b1, {F{1'b0}}};

  // global advance: the pipe moves unless a result is held
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage: active time, cases, difference
  logic [23:0]        in_elapsed, in_delay, in_dur;
  logic signed [31:0] in_start, in_end;
  logic [24:0]        act;
  logic               act_neg, act_full;

  assign in_elapsed = s_tdata[23:0];
  assign in_delay   = s_tdata[47:24];
  assign in_dur     = s_tdata[71:48];
  assign in_start   = s_tdata[103:72];
  assign in_end     = s_tdata[135:104];
  assign act        = {1'b0, in_elapsed} - {1'b0, in_delay};
  assign act_neg    = act[24];
  assign act_full   = (in_dur == 24'd0) || (act[23:0] >= in_dur);

  logic           a_valid, a_wait, a_full;
  logic [23:0]    a_act, a_dur;
  eti_pkg::side_t a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_act              <= act[23:0];
      a_dur              <= in_dur;
      a_wait             <= act_neg;
      a_full             <= act_full;
      a_side.func        <= s_tuser;
      a_side.start_value <= in_start;
      a_side.diff        <= {in_end[31], in_end} - {in_start[31], in_start};
      a_side.phase       <= act_neg  ? eti_pkg::PH_WAIT :
                            act_full ? eti_pkg::PH_DONE : eti_pkg::PH_RUN;
    end
  end

  // linear progress
  logic           d_valid;
  logic [W-1:0]   d_x;
  eti_pkg::side_t d_side;

  eti_div_pipe #(
    .FRAC_BITS (F)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .active    (a_act),
    .duration  (a_dur),
    .waiting   (a_wait),
    .full      (a_full),
    .in_side   (a_side),
    .out_valid (d_valid),
    .x         (d_x),
    .out_side  (d_side)
  );

  // bisection chain
  logic           c_valid [N+1];
  eti_pkg::side_t c_side  [N+1];
  logic [W-1:0]   c_x     [N+1];
  logic [W-1:0]   c_lo    [N+1];
  logic [W-1:0]   c_hi    [N+1];

  assign c_valid[0] = d_valid;
  assign c_side[0]  = d_side;
  assign c_x[0]     = d_x;
  assign c_lo[0]    = '0;
  assign c_hi[0]    = ONE;

  for (genvar i = 0; i < N; i++) begin : g_bisect
    eti_bisect_step #(
      .FRAC_BITS (F)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (c_valid[i]),
      .in_side   (c_side[i]),
      .x         (c_x[i]),
      .lo        (c_lo[i]),
      .hi        (c_hi[i]),
      .out_valid (c_valid[i+1]),
      .out_side  (c_side[i+1]),
      .x_out     (c_x[i+1]),
      .lo_out    (c_lo[i+1]),
      .hi_out    (c_hi[i+1])
    );
  end

  // y coordinate at the final parameter
  logic [W:0]     fin_sum;
  logic [W-1:0]   fin_t, y_s, y_t, y_x;
  logic           y_valid;
  eti_pkg::side_t y_side;

  assign fin_sum = {1'b0, c_lo[N]} + {1'b0, c_hi[N]};
  assign fin_t   = fin_sum[W:1];

  eti_bez_pipe #(
    .FRAC_BITS (F),
    .AUX_W     (W),
    .USE_Y     (1'b1)
  ) u_ybez (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid[N]),
    .t         (fin_t),
    .in_side   (c_side[N]),
    .in_aux    (c_x[N]),
    .out_valid (y_valid),
    .s         (y_s),
    .t_out     (y_t),
    .out_side  (y_side),
    .out_aux   (y_x)
  );

  // eased progress: curve inside the open interval, otherwise linear
  logic         is_curve;
  logic [W-1:0] e;
  logic [16:0]  e_q16;

  assign is_curve = (y_side.func == eti_pkg::FUNC_EASE    ||
                     y_side.func == eti_pkg::FUNC_EASE_IN ||
                     y_side.func == eti_pkg::FUNC_EASE_OUT ||
                     y_side.func == eti_pkg::FUNC_EASE_IN_OUT) &&
                    (y_x != '0) && (y_x < ONE);
  assign e = is_curve ? y_s : y_x;

  if (F >= 16) begin : g_q16_down
    logic [W-1:0] e_sh;
    assign e_sh  = e >> (F - 16);
    assign e_q16 = e_sh[16:0];
  end else begin : g_q16_up
    assign e_q16 = {e, {(16 - F){1'b0}}};
  end

  // product stage: difference times eased progress
  logic                 p_valid;
  logic signed [PW-1:0] p_prod;
  logic signed [31:0]   p_start;
  logic [16:0]          p_eq16;
  logic [1:0]           p_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= y_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod  <= PW'(y_side.diff) * PW'($signed({1'b0, e}));
      p_start <= y_side.start_value;
      p_eq16  <= e_q16;
      p_phase <= y_side.phase;
    end
  end

  // round half up, add to start, output register
  logic signed [PW-1:0] p_round;
  logic        [31:0]   value;

  assign p_round = (p_prod + (PW'(1) <<< (F - 1))) >>> F;
  assign value   = p_start + p_round[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'd0, p_eq16, value};
      m_tuser <= p_phase;
    end
  end

  // checks
  `ETI_ASSERT_NOW(a_wait_zero, m_tvalid && (m_tuser == eti_pkg::PH_WAIT), m_tdata[48:32] == 17'd0, "waiting word with nonzero progress")
  `ETI_ASSERT_NOW(a_done_one, m_tvalid && (m_tuser == eti_pkg::PH_DONE), m_tdata[48:32] == 17'd65536, "finished word without full progress")
  `ETI_ASSERT_NOW(a_run_below, m_tvalid && (m_tuser == eti_pkg::PH_RUN), m_tdata[48:32] <= 17'd65536, "running word with progress above one")
  `ETI_ASSERT_NOW(a_stall_in, m_tvalid && !m_tready, !s_tready, "input taken while a word is held")
  `ETI_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "held word dropped or changed")

endmodule

### test/eti_checker.sv
// ----------------------------------------------------------------------------
// eti_checker
// Watches both streams of the interpolator, predicts each result word from
// the accepted input word and compares it field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eti_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,   // elapsed, delay, duration, start, end
  input  logic [2:0]   s_tuser,   // func
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [55:0]  m_tdata,   // current_value, eased_progress, pad
  input  logic [1:0]   m_tuser,   // phase
  output int           fail_count,
  output int           pending,
  output int           word_count
);

  localparam int STEPS = eti_pkg::BISECT_STEPS_DEF;
  localparam int FB    = eti_pkg::FRAC_BITS_DEF;
  localparam longint unsigned UNIT = 64'd1 << FB;

  typedef struct packed {
    logic signed [31:0] value;
    logic [16:0]        progress;
    logic [1:0]         phase;
  } result_t;

  result_t expected_q[$];

  function automatic longint unsigned fx(longint unsigned num, longint unsigned den);
    return (num * UNIT + den / 2) / den;
  endfunction

  // one Bezier coordinate at parameter t, truncating each product
  function automatic longint unsigned bez(longint unsigned t, longint unsigned p1,
                                          longint unsigned p2);
    longint unsigned u, uu, tt, a, b, s;
    u  = UNIT - t;
    uu = (u * u) >> FB;
    tt = (t * t) >> FB;
    a  = (uu * t) >> FB;
    b  = (tt * u) >> FB;
    s  = ((a * 3 * p1) >> FB) + ((b * 3 * p2) >> FB) + ((tt * t) >> FB);
    return (s > UNIT) ? UNIT : s;
  endfunction

  function automatic longint unsigned ease(logic [2:0] fn, longint unsigned x);
    longint unsigned x1, y1, x2, y2, lo, hi, mid;
    x1 = 0; y1 = 0; x2 = UNIT; y2 = UNIT;
    case (fn)
      eti_pkg::FUNC_EASE: begin
        x1 = fx(25, 100); y1 = fx(10, 100); x2 = fx(25, 100);
      end
      eti_pkg::FUNC_EASE_IN:     begin x1 = fx(42, 100); end
      eti_pkg::FUNC_EASE_OUT:    begin x2 = fx(58, 100); end
      eti_pkg::FUNC_EASE_IN_OUT: begin x1 = fx(42, 100); x2 = fx(58, 100); end
      default:                   return x;
    endcase
    if (x == 0) return 0;
    if (x >= UNIT) return UNIT;
    lo = 0; hi = UNIT;
    for (int i = 0; i < STEPS; i++) begin
      mid = (lo + hi) >> 1;
      if (bez(mid, x1, x2) < x) lo = mid;
      else hi = mid;
    end
    return bez((lo + hi) >> 1, y1, y2);
  endfunction

  function automatic result_t interpolate(logic [135:0] d, logic [2:0] fn);
    result_t r;
    longint act, dv, p, q;
    longint signed sv, ev;
    longint unsigned dur, t, e;
    act = longint'(d[23:0]) - longint'(d[47:24]);
    dur = d[71:48];
    sv  = $signed(d[103:72]);
    ev  = $signed(d[135:104]);
    if (act < 0) begin
      r.value = sv[31:0]; r.progress = '0; r.phase = eti_pkg::PH_WAIT;
      return r;
    end
    if (dur == 0) t = UNIT;
    else begin
      t = (longint'(act) * UNIT) / dur;
      if (t > UNIT) t = UNIT;
    end
    e  = ease(fn, t);
    dv = ev - sv;
    p  = dv * longint'(e) + longint'(UNIT >> 1);
    // floor division, round half up
    if (p >= 0) q = p >>> FB;
    else q = -((-p + longint'(UNIT) - 1) >>> FB);
    q = sv + q;
    r.value    = q[31:0];
    r.progress = e[16:0];
    r.phase    = (t >= UNIT) ? eti_pkg::PH_DONE : eti_pkg::PH_RUN;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      fail_count <= 0;
      word_count <= 0;
      pending    <= 0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(interpolate(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        word_count <= word_count + 1;
        got.value = m_tdata[31:0]; got.progress = m_tdata[48:32]; got.phase = m_tuser;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("ERROR: value %h/%h progress %h/%h phase %0d/%0d (exp/got)",
                       want.value, got.value, want.progress, got.progress,
                       want.phase, got.phase);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

### test/tb_eased_transition_interpolator_top.sv
// ----------------------------------------------------------------------------
// tb_eased_transition_interpolator_top
// Drives directed and random transition steps with random gaps and stalls,
// including a long output hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_eased_transition_interpolator_top;

  localparam int LATENCY = 3 + eti_pkg::FRAC_BITS_DEF + 3 * (eti_pkg::BISECT_STEPS_DEF + 1);
  localparam int N_RANDOM = 2000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [55:0]  m_tdata;
  logic [1:0]   m_tuser;
  int           fail_count, pending, word_count;
  logic         hold_off = 0;

  always #6 clk = ~clk;

  eased_transition_interpolator_top dut (.*);

  eti_checker u_chk (.*);

  // send one word, then, if gaps is set, idle for a random gap
  task automatic send(logic [2:0] fn, logic [23:0] el, logic [23:0] dl, logic [23:0] du,
                      logic [31:0] sv, logic [31:0] ev, bit gaps);
    int gap;
    s_tvalid <= 1;
    s_tuser  <= fn;
    s_tdata  <= {ev, sv, du, dl, el};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [23:0] rand_time();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 3));
      1: return 24'($urandom_range(0, 2000));
      2: return 24'($urandom);
      default: return 24'hFFFFFF - 24'($urandom_range(0, 3));
    endcase
  endfunction

  // receiver: idles for a random time before each word, plus one long hold-off
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        @(posedge clk);
      end else begin
        w = $urandom_range(0, 3);
        if (w > 0) begin
          m_tready <= 0;
          repeat (w) @(posedge clk);
        end
        m_tready <= 1;
        @(posedge clk);
        while (!m_tvalid && !hold_off) @(posedge clk);
      end
    end
  end

  initial begin
    logic [23:0] el, du;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes, every curve, waiting, zero duration, endpoints
    send(eti_pkg::FUNC_LINEAR, 24'd5, 24'd10, 24'd100, 32'h0001_0000, 32'h0002_0000, 0);
    send(eti_pkg::FUNC_LINEAR, 24'd0, 24'hFFFFFF, 24'd0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send(eti_pkg::FUNC_LINEAR, 24'd10, 24'd10, 24'd0, 32'h0000_0000, 32'h0005_0000, 0);
    send(eti_pkg::FUNC_LINEAR, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         0);
    send(eti_pkg::FUNC_LINEAR, 24'hFFFFFF, 24'd0, 24'd1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    for (int f = 0; f < 8; f++) begin
      send(3'(f), 24'd0, 24'd0, 24'd1000, 32'h0000_0000, 32'h0010_0000, 0);
      send(3'(f), 24'd333, 24'd0, 24'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
    end
    send(eti_pkg::FUNC_EASE, 24'd1000, 24'd0, 24'd1000, 32'hFFFF_0000, 32'h0001_0000, 0);
    send(eti_pkg::FUNC_EASE_IN_OUT, 24'd1, 24'd0, 24'hFFFFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         0);
    // long receiver hold-off while the sender keeps offering words
    hold_off <= 1;
    fork
      begin
        repeat (LATENCY + 100) @(posedge clk);
        hold_off <= 0;
      end
      for (int i = 0; i < 120; i++)
        send(3'($urandom_range(0, 7)), 24'($urandom_range(0, 500)),
             24'($urandom_range(0, 100)), 24'($urandom_range(0, 400)),
             $urandom, $urandom, 0);
    join
    // random traffic, mostly inside the running window
    for (int i = 0; i < N_RANDOM; i++) begin
      du = rand_time();
      el = ($urandom_range(0, 3) != 0 && du != 0) ? 24'($urandom_range(0, du)) : rand_time();
      send(3'($urandom_range(0, 7)), el, ($urandom_range(0, 1) ? 24'd0 : rand_time()),
           du, $urandom, $urandom, $urandom_range(0, 3) != 0);
    end
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d result words over all curves, waiting, running and finished.",
             word_count);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
